@@ hdl/scpu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpu_pkg
// Types, codes and small helper functions shared by the 16-bit CPU core.
// ----------------------------------------------------------------------------
package scpu_pkg;

	// Number of general registers A, B, C, X, Y, Z, I, J.
	localparam int REG_COUNT = 8;

	// Command codes on the input stream.
	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_STEP    = 2'd1,
		CMD_READMEM = 2'd2,
		CMD_READREG = 2'd3
	} cmd_t;

	// Basic opcodes.
	typedef enum logic [3:0] {
		OP_NONBASIC = 4'h0,
		OP_SET      = 4'h1,
		OP_ADD      = 4'h2,
		OP_SUB      = 4'h3,
		OP_MUL      = 4'h4,
		OP_DIV      = 4'h5,
		OP_MOD      = 4'h6,
		OP_SHL      = 4'h7,
		OP_SHR      = 4'h8,
		OP_AND      = 4'h9,
		OP_BOR      = 4'ha,
		OP_XOR      = 4'hb,
		OP_IFE      = 4'hc,
		OP_IFN      = 4'hd,
		OP_IFG      = 4'he,
		OP_IFB      = 4'hf
	} op_t;

	// Non-basic opcode for JSR.
	localparam logic [5:0] NB_JSR = 6'h01;

	// Operand value codes.
	localparam logic [5:0] OV_REG_LAST  = 6'h07;
	localparam logic [5:0] OV_IND_LAST  = 6'h0f;
	localparam logic [5:0] OV_IDX_LAST  = 6'h17;
	localparam logic [5:0] OV_POP       = 6'h18;
	localparam logic [5:0] OV_PEEK      = 6'h19;
	localparam logic [5:0] OV_PUSH      = 6'h1a;
	localparam logic [5:0] OV_SP        = 6'h1b;
	localparam logic [5:0] OV_PC        = 6'h1c;
	localparam logic [5:0] OV_O         = 6'h1d;
	localparam logic [5:0] OV_NW_IND    = 6'h1e;
	localparam logic [5:0] OV_NW_LIT    = 6'h1f;
	localparam logic [5:0] OV_SHORT_LIT = 6'h20;

	// Register indexes for a register read command.
	localparam logic [15:0] RIDX_SP = 16'd8;
	localparam logic [15:0] RIDX_PC = 16'd9;
	localparam logic [15:0] RIDX_O  = 16'd10;

	localparam logic [15:0] HALT_PC = 16'hffff;

	// Kind of location an operand resolves to.
	typedef enum logic [2:0] {
		LK_REG,
		LK_MEM,
		LK_SP,
		LK_PC,
		LK_O,
		LK_LIT
	} loc_kind_t;

	// Resolved operand: register index, memory address or literal in val.
	typedef struct packed {
		loc_kind_t   kind;
		logic [15:0] val;
	} loc_t;

	// Result of the shared arithmetic unit.
	typedef struct packed {
		logic [15:0] r;
		logic [15:0] o;
		logic        o_we;
		logic        ok;
	} alu_res_t;

	// Status of the iterative divider.
	typedef struct packed {
		logic        done;
		logic [31:0] quot;
		logic [15:0] rem;
	} div_res_t;

	// States of the core sequencer.
	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MEMRD_WAIT,
		ST_FETCH_WAIT,
		ST_DECODE,
		ST_OPND,
		ST_NW_WAIT,
		ST_READ_B,
		ST_READ_B_WAIT,
		ST_READ_A,
		ST_READ_A_WAIT,
		ST_EXEC,
		ST_DIV_WAIT,
		ST_WRITE,
		ST_SKIP_WAIT,
		ST_JSR,
		ST_RESULT
	} st_t;

	// True when an operand code consumes a next word.
	function automatic logic uses_next(input logic [5:0] v);
		logic r;
		r = (v > OV_IND_LAST && v <= OV_IDX_LAST) || v == OV_NW_IND || v == OV_NW_LIT;
		return r;
	endfunction

	// Number of words an instruction occupies.
	function automatic logic [1:0] instr_words(input logic [15:0] w);
		logic [1:0] n;
		n = 2'd1;
		if (w[3:0] == OP_NONBASIC) begin
			if (uses_next(w[15:10]))
				n = 2'd2;
		end else begin
			if (uses_next(w[9:4]))
				n = n + 2'd1;
			if (uses_next(w[15:10]))
				n = n + 2'd1;
		end
		return n;
	endfunction

	// Base cycle cost of a basic opcode.
	function automatic logic [2:0] base_cycles(input logic [3:0] op);
		logic [2:0] c;
		case (op)
			OP_SET, OP_AND, OP_BOR, OP_XOR: c = 3'd1;
			OP_DIV, OP_MOD:                 c = 3'd3;
			OP_NONBASIC:                    c = 3'd0;
			default:                        c = 3'd2;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

@@ hdl/scpu_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpu_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module scpu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One access per cycle: write, or read into the output register.
	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		else
			rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

@@ hdl/scpu_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpu_alu
// Shared arithmetic, shift, logic and compare unit of the CPU core.
// ----------------------------------------------------------------------------
module scpu_alu
	import scpu_pkg::*;
(
	input  wire logic [3:0]  op,
	input  wire logic [15:0] x,
	input  wire logic [15:0] y,
	output alu_res_t         res
);

	logic [16:0] sum;
	logic [31:0] prod;
	logic [47:0] shl;
	logic [31:0] shr;

	always_comb begin
		sum  = {1'b0, x} + {1'b0, y};
		prod = x * y;
		shl  = (y < 16'd32) ? ({32'd0, x} << y[4:0]) : 48'd0;
		shr  = (y < 16'd32) ? ({x, 16'd0} >> y[4:0]) : 32'd0;
	end

	// Result, overflow word and test outcome for each opcode.
	always_comb begin
		res = '0;
		case (op)
			OP_SET: res.r = y;
			OP_ADD: begin
				res.r    = sum[15:0];
				res.o    = {15'd0, sum[16]};
				res.o_we = 1'b1;
			end
			OP_SUB: begin
				res.r    = x - y;
				res.o    = (x < y) ? 16'hffff : 16'd0;
				res.o_we = 1'b1;
			end
			OP_MUL: begin
				res.r    = prod[15:0];
				res.o    = prod[31:16];
				res.o_we = 1'b1;
			end
			// Division by zero; nonzero divisors go to the divider.
			OP_DIV: res.o_we = 1'b1;
			OP_MOD: res.r = 16'd0;
			OP_SHL: begin
				res.r    = shl[15:0];
				res.o    = shl[31:16];
				res.o_we = 1'b1;
			end
			OP_SHR: begin
				res.r    = (y < 16'd16) ? (x >> y[3:0]) : 16'd0;
				res.o    = shr[15:0];
				res.o_we = 1'b1;
			end
			OP_AND: res.r = x & y;
			OP_BOR: res.r = x | y;
			OP_XOR: res.r = x ^ y;
			OP_IFE: res.ok = (x == y);
			OP_IFN: res.ok = (x != y);
			OP_IFG: res.ok = (x > y);
			OP_IFB: res.ok = ((x & y) != 16'd0);
			default: res = '0;
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/scpu_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpu_div
// Radix-2 restoring divider of {x, 16'h0} by y, one quotient bit per cycle.
// The partial remainder after the upper sixteen bits is x mod y.
// ----------------------------------------------------------------------------
module scpu_div
	import scpu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] x,
	input  wire logic [15:0] y,
	output div_res_t         res
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [15:0] mod_q;
	logic [15:0] dsr_q;
	logic [31:0] dvd_q;
	logic [16:0] trial;
	logic        fits;
	logic [15:0] rem_next;

	// One restoring step.
	always_comb begin
		trial    = {rem_q, dvd_q[31]};
		fits     = trial >= {1'b0, dsr_q};
		rem_next = fits ? 16'(trial - {1'b0, dsr_q}) : trial[15:0];
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (&cnt_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend register fills with quotient bits from below.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= y;
			dvd_q <= {x, 16'd0};
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[30:0], fits};
			if (cnt_q == 5'd15)
				mod_q <= rem_next;
		end
	end

	assign res.done = done_q;
	assign res.quot = dvd_q;
	assign res.rem  = mod_q;

endmodule
`default_nettype wire

@@ hdl/sixteen_bit_cpu_core_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sixteen_bit_cpu_core_unit
// 16-bit word-addressed CPU with load, read and single-step commands.
// ----------------------------------------------------------------------------
// After reset the core clears its RAM, one word per cycle, and accepts no
// transaction meanwhile. Each command then returns one result transaction.
// A step spends extra states on every next word and every memory operand
// read, because all of them share the single RAM port; DIV and MOD with a
// nonzero divisor also wait on the shared bit-serial divider.
// MEM_WORDS must be a power of two; addresses wrap modulo MEM_WORDS.
module sixteen_bit_cpu_core_unit
	import scpu_pkg::*;
#(
	parameter int MEM_WORDS = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// cmd [1:0], addr [17:2], data [33:18], zero [39:34]
	input  wire logic [39:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// read_data [15:0], pc_after [31:16], cycles_used [34:32], halted [35],
	// zero [39:36]
	output logic      [39:0] m_axis_tdata
);

	localparam int AW = $clog2(MEM_WORDS);

	st_t state_q, state_d;

	logic [AW-1:0] clr_q;
	logic [15:0]   pc_q, sp_q, o_q;
	logic [15:0]   regs_q [REG_COUNT];
	logic [15:0]   inst_q, rd_q, x_q, y_q, res_q, ores_q;
	logic          owe_q, opnd_b_q;
	logic [2:0]    cyc_q;
	loc_t          loc_a_q, loc_b_q;
	logic          out_valid_q;
	logic [39:0]   out_data_q;

	logic [1:0]    in_cmd;
	logic [15:0]   in_addr, in_data;
	logic          in_acc;
	logic [3:0]    op;
	logic [5:0]    va, vb, v;
	logic [2:0]    rf_raddr;
	logic [15:0]   rf_rdata;
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [15:0]   ram_wdata, ram_rdata;
	loc_t          loc_imm, loc_nw, loc_rd;
	logic [15:0]   loc_rd_val;
	logic [15:0]   sp_dec;
	logic          div_start;
	alu_res_t      alu_res;
	div_res_t      div_res;
	logic          out_load;

	assign in_cmd  = s_axis_tdata[1:0];
	assign in_addr = s_axis_tdata[17:2];
	assign in_data = s_axis_tdata[33:18];
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;

	assign op = inst_q[3:0];
	assign va = inst_q[9:4];
	assign vb = inst_q[15:10];
	assign v  = opnd_b_q ? vb : va;

	assign sp_dec = sp_q - 16'd1;

	// Single register-file read port; the address follows the state.
	always_comb begin
		case (state_q)
			ST_IDLE:                 rf_raddr = in_addr[2:0];
			ST_READ_B:               rf_raddr = loc_b_q.val[2:0];
			ST_READ_A:               rf_raddr = loc_a_q.val[2:0];
			default:                 rf_raddr = v[2:0];
		endcase
	end
	assign rf_rdata = regs_q[rf_raddr];

	// Operand resolution without a next word.
	always_comb begin
		loc_imm.kind = LK_LIT;
		loc_imm.val  = {11'd0, v[4:0]};
		if (v <= OV_REG_LAST) begin
			loc_imm.kind = LK_REG;
			loc_imm.val  = {10'd0, v};
		end else if (v <= OV_IND_LAST) begin
			loc_imm.kind = LK_MEM;
			loc_imm.val  = rf_rdata;
		end else if (v == OV_POP || v == OV_PEEK) begin
			loc_imm.kind = LK_MEM;
			loc_imm.val  = sp_q;
		end else if (v == OV_PUSH) begin
			loc_imm.kind = LK_MEM;
			loc_imm.val  = sp_q - 16'd1;
		end else if (v == OV_SP) begin
			loc_imm.kind = LK_SP;
		end else if (v == OV_PC) begin
			loc_imm.kind = LK_PC;
		end else if (v == OV_O) begin
			loc_imm.kind = LK_O;
		end
	end

	// Operand resolution once the next word is back from RAM.
	always_comb begin
		loc_nw.kind = LK_MEM;
		loc_nw.val  = ram_rdata;
		if (v <= OV_IDX_LAST)
			loc_nw.val = ram_rdata + rf_rdata;
		else if (v == OV_NW_LIT)
			loc_nw.kind = LK_LIT;
	end

	// Value of a non-memory location for the operand being read.
	assign loc_rd = (state_q == ST_READ_B) ? loc_b_q : loc_a_q;
	always_comb begin
		case (loc_rd.kind)
			LK_REG:  loc_rd_val = rf_rdata;
			LK_SP:   loc_rd_val = sp_q;
			LK_PC:   loc_rd_val = pc_q;
			LK_O:    loc_rd_val = o_q;
			default: loc_rd_val = loc_rd.val;
		endcase
	end

	scpu_alu u_alu (
		.op  (op),
		.x   (x_q),
		.y   (y_q),
		.res (alu_res)
	);

	assign div_start = (state_q == ST_EXEC) && (op == OP_DIV || op == OP_MOD)
		&& (y_q != 16'd0);

	scpu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.x      (x_q),
		.y      (y_q),
		.res    (div_res)
	);

	scpu_ram #(
		.WIDTH (16),
		.DEPTH (MEM_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign out_load = (state_q == ST_RESULT) && (!out_valid_q || m_axis_tready);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	// Next state and RAM port control.
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = pc_q[AW-1:0];
		ram_wdata = 16'd0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
				if (&clr_q)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_acc) begin
					unique case (cmd_t'(in_cmd))
						CMD_LOAD: begin
							ram_we    = 1'b1;
							ram_addr  = in_addr[AW-1:0];
							ram_wdata = in_data;
							state_d   = ST_RESULT;
						end
						CMD_READMEM: begin
							ram_addr = in_addr[AW-1:0];
							state_d  = ST_MEMRD_WAIT;
						end
						CMD_READREG: state_d = ST_RESULT;
						CMD_STEP: state_d = (pc_q == HALT_PC) ? ST_RESULT : ST_FETCH_WAIT;
					endcase
				end
			end
			ST_MEMRD_WAIT: state_d = ST_RESULT;
			ST_FETCH_WAIT: state_d = ST_DECODE;
			ST_DECODE: begin
				if (op != OP_NONBASIC)
					state_d = ST_OPND;
				else if (va == NB_JSR)
					state_d = ST_OPND;
				else
					state_d = ST_RESULT;
			end
			ST_OPND: begin
				if (uses_next(v))
					state_d = ST_NW_WAIT;
				else if (!opnd_b_q)
					state_d = ST_OPND;
				else
					state_d = ST_READ_B;
			end
			ST_NW_WAIT: state_d = opnd_b_q ? ST_READ_B : ST_OPND;
			ST_READ_B: begin
				ram_addr = loc_b_q.val[AW-1:0];
				if (loc_b_q.kind == LK_MEM)
					state_d = ST_READ_B_WAIT;
				else
					state_d = (op == OP_NONBASIC) ? ST_JSR : ST_READ_A;
			end
			ST_READ_B_WAIT: state_d = (op == OP_NONBASIC) ? ST_JSR : ST_READ_A;
			ST_READ_A: begin
				ram_addr = loc_a_q.val[AW-1:0];
				state_d  = (loc_a_q.kind == LK_MEM) ? ST_READ_A_WAIT : ST_EXEC;
			end
			ST_READ_A_WAIT: state_d = ST_EXEC;
			ST_EXEC: begin
				if (op == OP_IFE || op == OP_IFN || op == OP_IFG || op == OP_IFB)
					state_d = alu_res.ok ? ST_RESULT : ST_SKIP_WAIT;
				else if (div_start)
					state_d = ST_DIV_WAIT;
				else
					state_d = ST_WRITE;
			end
			ST_DIV_WAIT: begin
				if (div_res.done)
					state_d = ST_WRITE;
			end
			ST_WRITE: begin
				ram_addr  = loc_a_q.val[AW-1:0];
				ram_wdata = res_q;
				ram_we    = (loc_a_q.kind == LK_MEM);
				state_d   = ST_RESULT;
			end
			ST_SKIP_WAIT: state_d = ST_RESULT;
			ST_JSR: begin
				ram_we    = 1'b1;
				ram_addr  = sp_dec[AW-1:0];
				ram_wdata = pc_q;
				state_d   = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Architectural state and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			pc_q     <= '0;
			sp_q     <= HALT_PC;
			o_q      <= '0;
			opnd_b_q <= 1'b0;
			cyc_q    <= '0;
			for (int i = 0; i < REG_COUNT; i++)
				regs_q[i] <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					cyc_q <= '0;
					if (in_acc && in_cmd == CMD_STEP && pc_q != HALT_PC)
						pc_q <= pc_q + 16'd1;
				end
				ST_DECODE: opnd_b_q <= (op == OP_NONBASIC);
				ST_OPND: begin
					if (uses_next(v)) begin
						pc_q  <= pc_q + 16'd1;
						cyc_q <= cyc_q + 3'd1;
					end else begin
						opnd_b_q <= 1'b1;
						if (v == OV_POP)
							sp_q <= sp_q + 16'd1;
						else if (v == OV_PUSH)
							sp_q <= sp_q - 16'd1;
					end
				end
				ST_NW_WAIT: opnd_b_q <= 1'b1;
				ST_EXEC: begin
					if (op == OP_IFE || op == OP_IFN || op == OP_IFG || op == OP_IFB)
						cyc_q <= cyc_q + 3'd2;
				end
				ST_WRITE: begin
					cyc_q <= cyc_q + base_cycles(op);
					// A write to O as the destination overrides the overflow value.
					if (owe_q && loc_a_q.kind != LK_O)
						o_q <= ores_q;
					case (loc_a_q.kind)
						LK_REG: regs_q[loc_a_q.val[2:0]] <= res_q;
						LK_SP:  sp_q <= res_q;
						LK_PC:  pc_q <= res_q;
						LK_O:   o_q  <= res_q;
						default: ;
					endcase
				end
				ST_SKIP_WAIT: begin
					pc_q  <= pc_q + {14'd0, instr_words(ram_rdata)};
					cyc_q <= cyc_q + 3'd1;
				end
				ST_JSR: begin
					sp_q  <= sp_q - 16'd1;
					pc_q  <= y_q;
					cyc_q <= cyc_q + 3'd2;
				end
				default: ;
			endcase
		end
	end

	// Instruction and operand datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rd_q <= '0;
				if (in_acc && in_cmd == CMD_READREG) begin
					if (in_addr < 16'(REG_COUNT))
						rd_q <= rf_rdata;
					else if (in_addr == RIDX_SP)
						rd_q <= sp_q;
					else if (in_addr == RIDX_PC)
						rd_q <= pc_q;
					else if (in_addr == RIDX_O)
						rd_q <= o_q;
				end
			end
			ST_MEMRD_WAIT: rd_q <= ram_rdata;
			ST_FETCH_WAIT: inst_q <= ram_rdata;
			ST_OPND: begin
				if (!uses_next(v)) begin
					if (opnd_b_q)
						loc_b_q <= loc_imm;
					else
						loc_a_q <= loc_imm;
				end
			end
			ST_NW_WAIT: begin
				if (opnd_b_q)
					loc_b_q <= loc_nw;
				else
					loc_a_q <= loc_nw;
			end
			ST_READ_B:      y_q <= loc_rd_val;
			ST_READ_B_WAIT: y_q <= ram_rdata;
			ST_READ_A:      x_q <= loc_rd_val;
			ST_READ_A_WAIT: x_q <= ram_rdata;
			ST_EXEC: begin
				res_q  <= alu_res.r;
				ores_q <= alu_res.o;
				owe_q  <= alu_res.o_we;
			end
			ST_DIV_WAIT: begin
				if (op == OP_DIV) begin
					res_q  <= div_res.quot[31:16];
					ores_q <= div_res.quot[15:0];
				end else begin
					res_q <= div_res.rem;
				end
			end
			default: ;
		endcase
	end

	// Output register: holds one result transaction until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_data_q <= {4'd0, (pc_q == HALT_PC), cyc_q, pc_q, rd_q};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 16-bit CPU core: loads short programs, steps
// them and reads memory and registers back, predicting each result in-line.
// ----------------------------------------------------------------------------
module tb;
	import scpu_pkg::*;

	typedef struct {
		cmd_t        cmd;
		bit   [15:0] addr;
		bit   [15:0] data;
	} cpu_cmd_t;

	typedef struct {
		bit [15:0] rd;
		bit [15:0] pc;
		bit [2:0]  cyc;
		bit        halted;
	} cpu_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;

	// Shadow machine state used to predict every result.
	bit [15:0]   cpu_mem [0:65535];
	bit [15:0]   cpu_reg [0:7];
	bit [15:0]   cpu_pc;
	bit [15:0]   cpu_sp;
	bit [15:0]   cpu_o;
	int unsigned step_cyc;

	cpu_cmd_t    cmd_queue[$];
	cpu_result_t result_queue[$];
	int          mismatches;
	int          tx_gap;
	int          rx_gap;

	sixteen_bit_cpu_core_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic bit [15:0] fetch_word();
		bit [15:0] w;
		w = cpu_mem[cpu_pc];
		cpu_pc = cpu_pc + 16'd1;
		step_cyc++;
		return w;
	endfunction

	function automatic bit takes_next(bit [5:0] v);
		return (v > OV_IND_LAST && v <= OV_IDX_LAST) || v == OV_NW_IND || v == OV_NW_LIT;
	endfunction

	function automatic bit [15:0] word_count(bit [15:0] w);
		bit [15:0] n;
		n = 16'd1;
		if (w[3:0] == OP_NONBASIC)
			return takes_next(w[15:10]) ? 16'd2 : 16'd1;
		if (takes_next(w[9:4]))
			n++;
		if (takes_next(w[15:10]))
			n++;
		return n;
	endfunction

	// Decode one operand code, applying its stack and next-word side effects.
	function automatic void operand_loc(input bit [5:0] v, output loc_kind_t k,
			output bit [15:0] w);
		k = LK_LIT;
		w = 16'd0;
		if (v <= OV_REG_LAST) begin
			k = LK_REG;
			w = 16'(v);
		end else if (v <= OV_IND_LAST) begin
			k = LK_MEM;
			w = cpu_reg[v[2:0]];
		end else if (v <= OV_IDX_LAST) begin
			k = LK_MEM;
			w = fetch_word();
			w = w + cpu_reg[v[2:0]];
		end else if (v == OV_POP) begin
			k = LK_MEM;
			w = cpu_sp;
			cpu_sp = cpu_sp + 16'd1;
		end else if (v == OV_PEEK) begin
			k = LK_MEM;
			w = cpu_sp;
		end else if (v == OV_PUSH) begin
			cpu_sp = cpu_sp - 16'd1;
			k = LK_MEM;
			w = cpu_sp;
		end else if (v == OV_SP) begin
			k = LK_SP;
		end else if (v == OV_PC) begin
			k = LK_PC;
		end else if (v == OV_O) begin
			k = LK_O;
		end else if (v == OV_NW_IND) begin
			k = LK_MEM;
			w = fetch_word();
		end else if (v == OV_NW_LIT) begin
			w = fetch_word();
		end else begin
			w = 16'(v - OV_SHORT_LIT);
		end
	endfunction

	function automatic bit [15:0] loc_value(loc_kind_t k, bit [15:0] w);
		case (k)
			LK_REG:  return cpu_reg[w[2:0]];
			LK_MEM:  return cpu_mem[w];
			LK_SP:   return cpu_sp;
			LK_PC:   return cpu_pc;
			LK_O:    return cpu_o;
			default: return w;
		endcase
	endfunction

	function automatic void loc_store(loc_kind_t k, bit [15:0] w, bit [15:0] val);
		case (k)
			LK_REG:  cpu_reg[w[2:0]] = val;
			LK_MEM:  cpu_mem[w] = val;
			LK_SP:   cpu_sp = val;
			LK_PC:   cpu_pc = val;
			LK_O:    cpu_o = val;
			default: ;
		endcase
	endfunction

	function automatic void execute_instr();
		bit [15:0] inst;
		bit [3:0]  op;
		bit [5:0]  va;
		bit [5:0]  vb;
		loc_kind_t ka;
		loc_kind_t kb;
		bit [15:0] wa;
		bit [15:0] wb;
		bit [15:0] x;
		bit [15:0] y;
		bit [15:0] r;
		bit [31:0] t;
		bit [63:0] s;
		bit        ok;
		bit        store;
		inst = fetch_word();
		op = inst[3:0];
		va = inst[9:4];
		vb = inst[15:10];
		r = 16'd0;
		store = 1'b1;
		step_cyc = 0;
		// Non-basic: only JSR does anything, the rest are one-word no-ops.
		if (op == OP_NONBASIC) begin
			if (va == NB_JSR) begin
				operand_loc(vb, kb, wb);
				y = loc_value(kb, wb);
				cpu_sp = cpu_sp - 16'd1;
				cpu_mem[cpu_sp] = cpu_pc;
				cpu_pc = y;
				step_cyc += 2;
			end
			return;
		end
		operand_loc(va, ka, wa);
		operand_loc(vb, kb, wb);
		y = loc_value(kb, wb);
		x = loc_value(ka, wa);
		case (op)
			OP_SET: begin
				r = y;
				step_cyc += 1;
			end
			OP_ADD: begin
				t = 32'(x) + 32'(y);
				r = t[15:0];
				cpu_o = {15'd0, t[16]};
				step_cyc += 2;
			end
			OP_SUB: begin
				r = x - y;
				cpu_o = (x < y) ? 16'hffff : 16'd0;
				step_cyc += 2;
			end
			OP_MUL: begin
				t = 32'(x) * 32'(y);
				r = t[15:0];
				cpu_o = t[31:16];
				step_cyc += 2;
			end
			OP_DIV: begin
				if (y == 16'd0) begin
					r = 16'd0;
					cpu_o = 16'd0;
				end else begin
					r = x / y;
					t = {x, 16'd0} / 32'(y);
					cpu_o = t[15:0];
				end
				step_cyc += 3;
			end
			OP_MOD: begin
				r = (y == 16'd0) ? 16'd0 : x % y;
				step_cyc += 3;
			end
			OP_SHL: begin
				s = (y < 16'd32) ? (64'(x) << y) : 64'd0;
				r = s[15:0];
				cpu_o = s[31:16];
				step_cyc += 2;
			end
			OP_SHR: begin
				r = (y < 16'd16) ? (x >> y) : 16'd0;
				t = (y < 16'd32) ? ({x, 16'd0} >> y) : 32'd0;
				cpu_o = t[15:0];
				step_cyc += 2;
			end
			OP_AND: begin
				r = x & y;
				step_cyc += 1;
			end
			OP_BOR: begin
				r = x | y;
				step_cyc += 1;
			end
			OP_XOR: begin
				r = x ^ y;
				step_cyc += 1;
			end
			default: begin
				store = 1'b0;
				case (op)
					OP_IFE:  ok = (x == y);
					OP_IFN:  ok = (x != y);
					OP_IFG:  ok = (x > y);
					default: ok = ((x & y) != 16'd0);
				endcase
				step_cyc += 2;
				// A failed test jumps over the whole next instruction unevaluated.
				if (!ok) begin
					cpu_pc = cpu_pc + word_count(cpu_mem[cpu_pc]);
					step_cyc++;
				end
			end
		endcase
		if (store)
			loc_store(ka, wa, r);
	endfunction

	function automatic cpu_result_t apply_cmd(cpu_cmd_t it);
		cpu_result_t res;
		res.rd = 16'd0;
		res.cyc = 3'd0;
		case (it.cmd)
			CMD_LOAD: cpu_mem[it.addr] = it.data;
			CMD_STEP: begin
				if (cpu_pc != HALT_PC) begin
					step_cyc = 0;
					execute_instr();
					res.cyc = step_cyc[2:0];
				end
			end
			CMD_READMEM: res.rd = cpu_mem[it.addr];
			default: begin
				if (it.addr < 16'd8)
					res.rd = cpu_reg[it.addr[2:0]];
				else if (it.addr == RIDX_SP)
					res.rd = cpu_sp;
				else if (it.addr == RIDX_PC)
					res.rd = cpu_pc;
				else if (it.addr == RIDX_O)
					res.rd = cpu_o;
			end
		endcase
		res.pc = cpu_pc;
		res.halted = (cpu_pc == HALT_PC);
		return res;
	endfunction

	// ---------------------------------------------------------------- stimulus

	// Queue one command and record the result it must produce.
	task automatic issue(cmd_t c, bit [15:0] a, bit [15:0] d);
		cpu_cmd_t it;
		it.cmd = c;
		it.addr = a;
		it.data = d;
		cmd_queue.push_back(it);
		result_queue.push_back(apply_cmd(it));
	endtask

	function automatic bit [15:0] encode(op_t op, bit [5:0] a, bit [5:0] b);
		return {b, a, op};
	endfunction

	// Place an instruction with up to two next words at the PC, then step it.
	task automatic run_instr(bit [15:0] w0, bit [15:0] w1, bit [15:0] w2, int n);
		bit [15:0] at;
		at = cpu_pc;
		issue(CMD_LOAD, at, w0);
		if (n > 1)
			issue(CMD_LOAD, at + 16'd1, w1);
		if (n > 2)
			issue(CMD_LOAD, at + 16'd2, w2);
		issue(CMD_STEP, 16'd0, 16'd0);
	endtask

	function automatic bit [15:0] rand_operand_word();
		return ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 40)) : 16'($urandom);
	endfunction

	task automatic random_program_step();
		bit [3:0]  op;
		bit [5:0]  a;
		bit [5:0]  b;
		bit [15:0] w0;
		op = 4'($urandom_range(0, 15));
		a = 6'($urandom_range(0, 63));
		b = 6'($urandom_range(0, 63));
		if (op == OP_NONBASIC && $urandom_range(0, 3) != 0)
			a = NB_JSR;
		// Writes to the PC are kept rare so the core seldom wanders off.
		if (op != OP_NONBASIC && a == OV_PC && $urandom_range(0, 3) != 0)
			a = 6'd0;
		w0 = {b, a, op};
		run_instr(w0, rand_operand_word(), rand_operand_word(),
			$urandom_range(1, 3));
	endtask

	initial begin
		int k;
		arst_n = 1'b0;
		for (k = 0; k < 8; k++)
			cpu_reg[k] = 16'd0;
		cpu_pc = 16'd0;
		cpu_sp = HALT_PC;
		cpu_o = 16'd0;
		mismatches = 0;

		// Directed: register reads past the end, extreme addresses and fields.
		issue(CMD_READREG, 16'd11, 16'hffff);
		issue(CMD_READREG, RIDX_SP, 16'd0);
		issue(CMD_LOAD, 16'hffff, 16'hffff);
		issue(CMD_READMEM, 16'hffff, 16'd0);
		// Reserved non-basic opcode, then carry out of ADD.
		run_instr(encode(OP_NONBASIC, 6'h02, 6'h00), 16'd0, 16'd0, 1);
		run_instr(encode(OP_SET, 6'h00, OV_NW_LIT), 16'hffff, 16'd0, 2);
		run_instr(encode(OP_ADD, 6'h00, 6'h21), 16'd0, 16'd0, 1);
		// Division and modulo by zero, a literal destination, very large shifts.
		run_instr(encode(OP_DIV, 6'h00, 6'h01), 16'd0, 16'd0, 1);
		run_instr(encode(OP_MOD, 6'h00, OV_SHORT_LIT), 16'd0, 16'd0, 1);
		run_instr(encode(OP_SUB, 6'h25, OV_O), 16'd0, 16'd0, 1);
		run_instr(encode(OP_SHR, 6'h01, OV_NW_LIT), 16'd40, 16'd0, 2);
		// Failed test skips a three-word instruction; JSR pushes the return PC.
		run_instr(encode(OP_IFE, 6'h00, 6'h21), encode(OP_SET, OV_NW_IND, OV_NW_LIT),
			16'h1234, 3);
		run_instr(encode(OP_NONBASIC, NB_JSR, OV_NW_LIT), 16'h0100, 16'd0, 2);

		// Random part: mostly loaded-and-stepped instructions with random content.
		while (cmd_queue.size() < 730) begin
			k = $urandom_range(0, 99);
			if (k < 60)
				random_program_step();
			else if (k < 68)
				issue(CMD_STEP, 16'($urandom), 16'($urandom));
			else if (k < 78)
				issue(CMD_LOAD, ($urandom_range(0, 1) == 0) ? cpu_sp : 16'($urandom),
					16'($urandom));
			else if (k < 89)
				issue(CMD_READMEM, ($urandom_range(0, 1) == 0) ? cpu_sp : 16'($urandom),
					16'($urandom));
			else
				issue(CMD_READREG, ($urandom_range(0, 3) == 0) ? 16'($urandom)
					: 16'($urandom_range(0, 15)), 16'($urandom));
		end

		// Finish by jumping to the halt address; further steps do nothing.
		run_instr(encode(OP_SET, OV_PC, OV_NW_LIT), HALT_PC, 16'd0, 2);
		issue(CMD_STEP, 16'd0, 16'd0);
		issue(CMD_READREG, RIDX_PC, 16'd0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_queue.size() > 0 || s_axis_tvalid || result_queue.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("PASS sixteen_bit_cpu_core_unit");
		else
			$display("FAIL sixteen_bit_cpu_core_unit");
		$finish;
	end

	// Watchdog covering the RAM clearing pass and the slowest legal run.
	initial begin
		#10_000_000;
		$display("FAIL sixteen_bit_cpu_core_unit");
		$finish;
	end

	// ---------------------------------------------------------------- driver

	// Present commands in order with random gaps, none near the end.
	always @(posedge clk or negedge arst_n) begin
		cpu_cmd_t it;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 40'd0;
			tx_gap <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (cmd_queue.size() > 0) begin
				it = cmd_queue.pop_front();
				s_axis_tdata <= {6'd0, it.data, it.addr, it.cmd};
				s_axis_tvalid <= 1'b1;
				if (cmd_queue.size() > 80 && $urandom_range(0, 7) == 0)
					tx_gap <= $urandom_range(1, 18);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result backpressure in random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_gap <= 0;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (cmd_queue.size() > 80 && $urandom_range(0, 9) == 0)
				rx_gap <= $urandom_range(1, 18);
		end
	end

	// ---------------------------------------------------------------- monitor

	// Compare each result transaction field by field with the oldest prediction.
	always @(posedge clk) begin
		cpu_result_t want;
		bit          bad;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (result_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", m_axis_tdata);
			end else begin
				want = result_queue.pop_front();
				bad = (m_axis_tdata[15:0] !== want.rd) || (m_axis_tdata[31:16] !== want.pc)
					|| (m_axis_tdata[34:32] !== want.cyc)
					|| (m_axis_tdata[35] !== want.halted);
				if (bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: read_data %h/%h pc %h/%h cycles %0d/%0d halted %b/%b",
							want.rd, m_axis_tdata[15:0], want.pc, m_axis_tdata[31:16],
							want.cyc, m_axis_tdata[34:32], want.halted, m_axis_tdata[35]);
				end
			end
		end
	end

endmodule
